/* rtl/fpre_pkg.sv */
// ----------------------------------------------------------------------------
// fpre_pkg
// Shared types, constants and estimate ROMs for the fp reciprocal estimate unit
// ----------------------------------------------------------------------------
`default_nettype none

package fpre_pkg;

  typedef enum logic {
    CMD_RSQRT = 1'b0,
    CMD_RECIP = 1'b1
  } cmd_e;

  localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] BIG_SINGLE  = 64'h47EF_FFFF_E000_0000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [10:0] EXP_MAX     = 11'h7FF;
  localparam logic [10:0] RCP_EXP_LO  = 11'd895;
  localparam logic [10:0] RCP_EXP_HI  = 11'd1149;
  localparam logic [10:0] RCP_EXP_OFS = 11'h7FD;
  localparam logic [12:0] RSQ_EXP_OFS = 13'hBFC;

  typedef struct packed {
    logic [25:0]        base;
    logic signed [11:0] slope;
  } rom_pair_t;

  // stage 1 -> stage 2
  typedef struct packed {
    logic        cmd;
    logic        sign;
    logic [10:0] exp;
    logic [51:0] mant;
    logic [5:0]  lzc;
    logic        special;
    logic [63:0] spec_res;
  } s1_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic               cmd;
    logic               sign;
    logic [10:0]        exp;
    logic [25:0]        base;
    logic signed [11:0] slope;
    logic [10:0]        rem;
    logic               special;
    logic [63:0]        spec_res;
  } s2_t;

  // stage 3 -> stage 4
  typedef struct packed {
    logic               cmd;
    logic               sign;
    logic [10:0]        exp;
    logic [25:0]        base;
    logic signed [23:0] prod;
    logic               special;
    logic [63:0]        spec_res;
  } s3_t;

  function automatic rom_pair_t rsq_rom(input logic [4:0] idx);
    rom_pair_t r;
    case (idx)
      5'd0:  r = '{26'h1a7e800, -12'sh568};
      5'd1:  r = '{26'h17cb800, -12'sh4f3};
      5'd2:  r = '{26'h1552800, -12'sh48d};
      5'd3:  r = '{26'h130c000, -12'sh435};
      5'd4:  r = '{26'h10f2000, -12'sh3e7};
      5'd5:  r = '{26'h0eff000, -12'sh3a2};
      5'd6:  r = '{26'h0d2e000, -12'sh365};
      5'd7:  r = '{26'h0b7c000, -12'sh32e};
      5'd8:  r = '{26'h09e5000, -12'sh2fc};
      5'd9:  r = '{26'h0867000, -12'sh2d0};
      5'd10: r = '{26'h06ff000, -12'sh2a8};
      5'd11: r = '{26'h05ab800, -12'sh283};
      5'd12: r = '{26'h046a000, -12'sh261};
      5'd13: r = '{26'h0339800, -12'sh243};
      5'd14: r = '{26'h0218800, -12'sh226};
      5'd15: r = '{26'h0105800, -12'sh20b};
      5'd16: r = '{26'h3ffa000, -12'sh7a4};
      5'd17: r = '{26'h3c29000, -12'sh700};
      5'd18: r = '{26'h38aa000, -12'sh670};
      5'd19: r = '{26'h3572000, -12'sh5f2};
      5'd20: r = '{26'h3279000, -12'sh584};
      5'd21: r = '{26'h2fb7000, -12'sh524};
      5'd22: r = '{26'h2d26000, -12'sh4cc};
      5'd23: r = '{26'h2ac0000, -12'sh47e};
      5'd24: r = '{26'h2881000, -12'sh43a};
      5'd25: r = '{26'h2665000, -12'sh3fa};
      5'd26: r = '{26'h2468000, -12'sh3c2};
      5'd27: r = '{26'h2287000, -12'sh38e};
      5'd28: r = '{26'h20c1000, -12'sh35e};
      5'd29: r = '{26'h1f12000, -12'sh332};
      5'd30: r = '{26'h1d79000, -12'sh30a};
      default: r = '{26'h1bf4000, -12'sh2e6};
    endcase
    return r;
  endfunction

  function automatic rom_pair_t rcp_rom(input logic [4:0] idx);
    rom_pair_t r;
    case (idx)
      5'd0:  r = '{26'h7ff800, 12'sh3e1};
      5'd1:  r = '{26'h783800, 12'sh3a7};
      5'd2:  r = '{26'h70ea00, 12'sh371};
      5'd3:  r = '{26'h6a0800, 12'sh340};
      5'd4:  r = '{26'h638800, 12'sh313};
      5'd5:  r = '{26'h5d6200, 12'sh2ea};
      5'd6:  r = '{26'h579000, 12'sh2c4};
      5'd7:  r = '{26'h520800, 12'sh2a0};
      5'd8:  r = '{26'h4cc800, 12'sh27f};
      5'd9:  r = '{26'h47ca00, 12'sh261};
      5'd10: r = '{26'h430800, 12'sh245};
      5'd11: r = '{26'h3e8000, 12'sh22a};
      5'd12: r = '{26'h3a2c00, 12'sh212};
      5'd13: r = '{26'h360800, 12'sh1fb};
      5'd14: r = '{26'h321400, 12'sh1e5};
      5'd15: r = '{26'h2e4a00, 12'sh1d1};
      5'd16: r = '{26'h2aa800, 12'sh1be};
      5'd17: r = '{26'h272c00, 12'sh1ac};
      5'd18: r = '{26'h23d600, 12'sh19b};
      5'd19: r = '{26'h209e00, 12'sh18b};
      5'd20: r = '{26'h1d8800, 12'sh17c};
      5'd21: r = '{26'h1a9000, 12'sh16e};
      5'd22: r = '{26'h17ae00, 12'sh15b};
      5'd23: r = '{26'h14f800, 12'sh15b};
      5'd24: r = '{26'h124400, 12'sh143};
      5'd25: r = '{26'h0fbe00, 12'sh143};
      5'd26: r = '{26'h0d3800, 12'sh12d};
      5'd27: r = '{26'h0ade00, 12'sh12d};
      5'd28: r = '{26'h088400, 12'sh11a};
      5'd29: r = '{26'h065000, 12'sh11a};
      5'd30: r = '{26'h041c00, 12'sh108};
      default: r = '{26'h020c00, 12'sh106};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/fpre_decode.sv */
// ----------------------------------------------------------------------------
// fpre_decode
// Stage 1: special operand decode and leading zero count of the mantissa
// ----------------------------------------------------------------------------
`default_nettype none

module fpre_decode (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire logic         cmd_i,
  input  wire logic [63:0]  operand_bits_i,
  output logic              valid_o,
  input  wire logic         ready_i,
  output fpre_pkg::s1_t     data_o
);
  import fpre_pkg::*;

  logic        valid_q;
  s1_t         data_q, data_d;
  logic        adv;
  logic        sign;
  logic [10:0] exp;
  logic [51:0] mant;
  logic        is_zero, is_inf, is_nan;

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  assign sign = operand_bits_i[63];
  assign exp  = operand_bits_i[62:52];
  assign mant = operand_bits_i[51:0];

  assign is_zero = (exp == '0) && (mant == '0);
  assign is_inf  = (exp == EXP_MAX) && (mant == '0);
  assign is_nan  = (exp == EXP_MAX) && (mant != '0);

  always_comb begin
    data_d          = '0;
    data_d.cmd      = cmd_i;
    data_d.sign     = sign;
    data_d.exp      = exp;
    data_d.mant     = mant;
    data_d.special  = 1'b1;
    data_d.spec_res = '0;

    // priority encoder, lowest set bit is overridden by higher ones
    for (int i = 0; i < 52; i++) begin
      if (mant[i]) begin
        data_d.lzc = 6'(51 - i);
      end
    end

    if (is_zero) begin
      data_d.spec_res = {sign, EXP_MAX, 52'd0};
    end else if (is_nan) begin
      data_d.spec_res = operand_bits_i | QUIET_BIT;
    end else if (cmd_i == CMD_RSQRT) begin
      if (is_inf) begin
        data_d.spec_res = sign ? DEFAULT_NAN : 64'd0;
      end else if (sign) begin
        data_d.spec_res = DEFAULT_NAN;
      end else begin
        data_d.special = 1'b0;
      end
    end else begin
      if (is_inf || exp >= RCP_EXP_HI) begin
        data_d.spec_res = {sign, 63'd0};
      end else if (exp < RCP_EXP_LO) begin
        data_d.spec_res = {sign, 63'd0} | BIG_SINGLE;
      end else begin
        data_d.special = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/fpre_lookup.sv */
// ----------------------------------------------------------------------------
// fpre_lookup
// Stage 2: subnormal normalize, result exponent and base/slope ROM lookup
// ----------------------------------------------------------------------------
`default_nettype none

module fpre_lookup (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  fpre_pkg::s1_t data_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output fpre_pkg::s2_t data_o
);
  import fpre_pkg::*;

  logic               valid_q;
  s2_t                data_q, data_d;
  logic               adv;
  logic [6:0]         shamt;
  logic [51:0]        mant_n;
  logic signed [12:0] e_s;
  logic [12:0]        diff;
  rom_pair_t          rom;

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // subnormal: shift leading one out past the top, exponent becomes -lzc
  assign shamt  = 7'(data_i.lzc) + 7'd1;
  assign mant_n = (data_i.exp == '0) ? (data_i.mant << shamt) : data_i.mant;
  assign e_s    = (data_i.exp == '0) ? -$signed({7'd0, data_i.lzc})
                                     : $signed({2'b00, data_i.exp});
  assign diff   = RSQ_EXP_OFS - 13'(e_s);

  always_comb begin
    data_d          = '0;
    data_d.cmd      = data_i.cmd;
    data_d.sign     = data_i.sign;
    data_d.special  = data_i.special;
    data_d.spec_res = data_i.spec_res;
    if (data_i.cmd == CMD_RSQRT) begin
      rom         = rsq_rom({e_s[0], mant_n[51:48]});
      data_d.exp  = diff[11:1];
      data_d.rem  = mant_n[47:37];
    end else begin
      rom         = rcp_rom(data_i.mant[51:47]);
      data_d.exp  = RCP_EXP_OFS - data_i.exp;
      data_d.rem  = {1'b0, data_i.mant[46:37]};
    end
    data_d.base  = rom.base;
    data_d.slope = rom.slope;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/fpre_mul.sv */
// ----------------------------------------------------------------------------
// fpre_mul
// Stage 3: slope times remainder for the linear interpolation
// ----------------------------------------------------------------------------
`default_nettype none

module fpre_mul (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  fpre_pkg::s2_t data_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output fpre_pkg::s3_t data_o
);
  import fpre_pkg::*;

  logic valid_q;
  s3_t  data_q, data_d;
  logic adv;

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d.cmd      = data_i.cmd;
    data_d.sign     = data_i.sign;
    data_d.exp      = data_i.exp;
    data_d.base     = data_i.base;
    data_d.special  = data_i.special;
    data_d.spec_res = data_i.spec_res;
    data_d.prod     = 24'(data_i.slope * $signed({1'b0, data_i.rem}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/fpre_pack.sv */
// ----------------------------------------------------------------------------
// fpre_pack
// Stage 4: interpolation add and result assembly into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module fpre_pack (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  fpre_pkg::s3_t    data_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [63:0]      result_o
);
  import fpre_pkg::*;

  logic        valid_q;
  logic [63:0] result_q, result_d;
  logic        adv;
  logic [25:0] prod_ext;
  logic [25:0] half;
  logic [25:0] val;

  assign adv      = !valid_q || ready_i;
  assign ready_o  = adv;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  // only the low mantissa bits survive, so modular 26-bit math is enough
  assign prod_ext = 26'($signed(data_i.prod));
  assign half     = (prod_ext + 26'd1) >> 1;

  always_comb begin
    if (data_i.cmd == CMD_RSQRT) begin
      val      = data_i.base + prod_ext;
      result_d = {1'b0, data_i.exp, val, 26'd0};
    end else begin
      val      = data_i.base - half;
      result_d = {data_i.sign, data_i.exp, val[22:0], 29'd0};
    end
    if (data_i.special) begin
      result_d = data_i.spec_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      result_q <= result_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/fp_reciprocal_estimate_unit_top.sv */
// path: request accept, then decode, lookup, mul and pack registers, then result valid
// throughput: one request per cycle without output stall; four stages, no shared unit
// each stage holds its item while the next one is full; nothing is dropped or repeated
// reset: asynchronous, clears only the stage valid bits; data registers are not reset
// ----------------------------------------------------------------------------
// fp_reciprocal_estimate_unit_top
// Double precision reciprocal and reciprocal square root estimate pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module fp_reciprocal_estimate_unit_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [63:0] operand_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      result_bits_o
);
  import fpre_pkg::*;

  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  logic s3_valid, s3_ready;
  s1_t  s1_data;
  s2_t  s2_data;
  s3_t  s3_data;

  fpre_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (in_ready_o),
    .cmd_i          (cmd_i),
    .operand_bits_i (operand_bits_i),
    .valid_o        (s1_valid),
    .ready_i        (s1_ready),
    .data_o         (s1_data)
  );

  fpre_lookup u_lookup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  fpre_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  fpre_pack u_pack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s3_valid),
    .ready_o  (s3_ready),
    .data_i   (s3_data),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (result_bits_o)
  );

endmodule

`default_nettype wire

/* rtl/fpre_checker.sv */
// ----------------------------------------------------------------------------
// fpre_checker
// Port-level checks for the fp reciprocal estimate unit, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

module fpre_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        cmd_i,
  input wire logic [63:0] operand_bits_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] result_bits_o
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o && (cmd_i || !cmd_i)
                   && (operand_bits_i == operand_bits_i);

  // a stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(result_bits_o))
    else $error("result changed while stalled");

  // with the output draining, the pipeline never pushes back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("request refused although output is free");

  // while the output keeps draining, an accepted request reaches the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_ready_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind fp_reciprocal_estimate_unit_top fpre_checker u_fpre_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .cmd_i          (cmd_i),
  .operand_bits_i (operand_bits_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_bits_o  (result_bits_o)
);

`default_nettype wire

/* tb/sv/fpre_estimate_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpre_estimate_checker
// Watches the request and result channels of the estimate unit, predicts each
// result bit for bit and compares results in order
// ----------------------------------------------------------------------------

module fpre_estimate_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic        cmd_i,
  input  wire logic [63:0] operand_bits_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [63:0] result_bits_i,
  output int               outstanding_o,
  output int               fail_count_o
);
  import fpre_pkg::*;

  // base/slope interpolation tables
  int rsq_base [32] = '{
    'h1a7e800, 'h17cb800, 'h1552800, 'h130c000, 'h10f2000, 'h0eff000, 'h0d2e000, 'h0b7c000,
    'h09e5000, 'h0867000, 'h06ff000, 'h05ab800, 'h046a000, 'h0339800, 'h0218800, 'h0105800,
    'h3ffa000, 'h3c29000, 'h38aa000, 'h3572000, 'h3279000, 'h2fb7000, 'h2d26000, 'h2ac0000,
    'h2881000, 'h2665000, 'h2468000, 'h2287000, 'h20c1000, 'h1f12000, 'h1d79000, 'h1bf4000
  };
  int rsq_slope [32] = '{
    -'h568, -'h4f3, -'h48d, -'h435, -'h3e7, -'h3a2, -'h365, -'h32e,
    -'h2fc, -'h2d0, -'h2a8, -'h283, -'h261, -'h243, -'h226, -'h20b,
    -'h7a4, -'h700, -'h670, -'h5f2, -'h584, -'h524, -'h4cc, -'h47e,
    -'h43a, -'h3fa, -'h3c2, -'h38e, -'h35e, -'h332, -'h30a, -'h2e6
  };
  int rcp_base [32] = '{
    'h7ff800, 'h783800, 'h70ea00, 'h6a0800, 'h638800, 'h5d6200, 'h579000, 'h520800,
    'h4cc800, 'h47ca00, 'h430800, 'h3e8000, 'h3a2c00, 'h360800, 'h321400, 'h2e4a00,
    'h2aa800, 'h272c00, 'h23d600, 'h209e00, 'h1d8800, 'h1a9000, 'h17ae00, 'h14f800,
    'h124400, 'h0fbe00, 'h0d3800, 'h0ade00, 'h088400, 'h065000, 'h041c00, 'h020c00
  };
  int rcp_slope [32] = '{
    'h3e1, 'h3a7, 'h371, 'h340, 'h313, 'h2ea, 'h2c4, 'h2a0,
    'h27f, 'h261, 'h245, 'h22a, 'h212, 'h1fb, 'h1e5, 'h1d1,
    'h1be, 'h1ac, 'h19b, 'h18b, 'h17c, 'h16e, 'h15b, 'h15b,
    'h143, 'h143, 'h12d, 'h12d, 'h11a, 'h11a, 'h108, 'h106
  };

  logic [63:0] pending_estimates_q [$];
  int          mismatch_count = 0;

  function automatic logic [63:0] rsqrt_estimate(input logic [63:0] x);
    logic        sgn;
    logic [52:0] m;
    int          e;
    logic [31:0] ex_calc;
    logic [4:0]  idx;
    logic [10:0] rem;
    longint      v;
    sgn = x[63];
    m   = {1'b0, x[51:0]};
    e   = int'(x[62:52]);
    if (e == 0 && m == '0) return {sgn, EXP_MAX, 52'd0};
    if (e == int'(EXP_MAX)) begin
      if (m == '0) return sgn ? DEFAULT_NAN : 64'd0;
      return x | QUIET_BIT;
    end
    if (sgn) return DEFAULT_NAN;
    // subnormal: shift leading one up to the hidden position
    if (e == 0) begin
      while (!m[52]) begin
        m = m << 1;
        e = e - 1;
      end
      e = e + 1;
    end
    ex_calc = 32'(int'(RSQ_EXP_OFS) - e);
    idx     = {e[0], m[51:48]};
    rem     = m[47:37];
    v       = longint'(rsq_base[idx]) + longint'(rsq_slope[idx]) * longint'(rem);
    return {1'b0, ex_calc[11:1], v[25:0], 26'd0};
  endfunction

  function automatic logic [63:0] recip_estimate(input logic [63:0] x);
    logic        sgn;
    logic [10:0] e;
    logic [4:0]  idx;
    logic [9:0]  rem;
    longint      v;
    sgn = x[63];
    e   = x[62:52];
    if (e == '0 && x[51:0] == '0) return {sgn, EXP_MAX, 52'd0};
    if (e == EXP_MAX) begin
      if (x[51:0] == '0) return {sgn, 63'd0};
      return x | QUIET_BIT;
    end
    if (e < RCP_EXP_LO) return {sgn, BIG_SINGLE[62:0]};
    if (e >= RCP_EXP_HI) return {sgn, 63'd0};
    idx = x[51:47];
    rem = x[46:37];
    v   = longint'(rcp_base[idx])
        - (longint'(rcp_slope[idx]) * longint'(rem) + 64'sd1) / 64'sd2;
    return {sgn, 11'(RCP_EXP_OFS - e), v[22:0], 29'd0};
  endfunction

  function automatic logic [63:0] predict_estimate(input cmd_e cmd, input logic [63:0] x);
    return (cmd == CMD_RSQRT) ? rsqrt_estimate(x) : recip_estimate(x);
  endfunction

  always @(posedge clk_i) begin : track
    logic [63:0] want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (pending_estimates_q.size() == 0) begin
          $error("result_bits: expected none, actual %h", result_bits_i);
          mismatch_count++;
        end else begin
          want = pending_estimates_q.pop_front();
          if (result_bits_i !== want) begin
            $error("result_bits: expected %h, actual %h", want, result_bits_i);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        pending_estimates_q.push_back(predict_estimate(cmd_e'(cmd_i), operand_bits_i));
    end
    outstanding_o <= pending_estimates_q.size();
    fail_count_o  <= mismatch_count;
  end

endmodule

/* tb/sv/tb_fp_reciprocal_estimate_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fp_reciprocal_estimate_unit_top
// Drives directed and random estimate requests with random idling on both
// channels; the checker predicts and compares every result
// ----------------------------------------------------------------------------

module tb_fp_reciprocal_estimate_unit_top;
  import fpre_pkg::*;

  localparam int NUM_RANDOM = 2000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CMD_RSQRT;
  logic [63:0] operand_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] result_bits;
  int          outstanding;
  int          fail_count;

  bit gaps_on = 1'b1;
  bit quiet_tail = 1'b0;
  bit hold_req = 1'b0;

  always #1 clk = ~clk;

  fp_reciprocal_estimate_unit_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .operand_bits_i (operand_bits),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_bits_o  (result_bits)
  );

  fpre_estimate_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .cmd_i          (cmd),
    .operand_bits_i (operand_bits),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_bits_i  (result_bits),
    .outstanding_o  (outstanding),
    .fail_count_o   (fail_count)
  );

  task automatic send_request(input cmd_e c, input logic [63:0] op);
    in_valid     <= 1'b1;
    cmd          <= c;
    operand_bits <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // drop valid and wait for every outstanding request to come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [63:0] random_operand();
    logic [63:0] r;
    logic [10:0] ex;
    logic        sgn;
    int          kind;
    r    = {$urandom, $urandom};
    sgn  = ($urandom_range(0, 3) == 0);
    kind = $urandom_range(0, 15);
    case (kind)
      0: return {r[63], 63'd0};
      1: return {r[63], EXP_MAX, 52'd0};
      2: begin
        if (r[51:0] == '0) r[0] = 1'b1;
        return {r[63], EXP_MAX, r[51:0]};
      end
      3, 4: begin
        // subnormals with every leading-zero count
        r[51:0] = r[51:0] >> $urandom_range(0, 51);
        if (r[51:0] == '0) r[0] = 1'b1;
        return {sgn, 11'd0, r[51:0]};
      end
      5: begin
        case ($urandom_range(0, 5))
          0: ex = RCP_EXP_LO - 11'd1;
          1: ex = RCP_EXP_LO;
          2: ex = RCP_EXP_LO + 11'd1;
          3: ex = RCP_EXP_HI - 11'd2;
          4: ex = RCP_EXP_HI - 11'd1;
          default: ex = RCP_EXP_HI;
        endcase
        return {r[63], ex, r[51:0]};
      end
      6: return r;
      7: begin
        case ($urandom_range(0, 2))
          0: ex = 11'd1;
          1: ex = EXP_MAX - 11'd1;
          default: ex = 11'h3FF;
        endcase
        return {sgn, ex, r[51:0]};
      end
      default: begin
        // mostly inside the range where the reciprocal is interpolated
        if (kind < 12) ex = 11'($urandom_range(int'(RCP_EXP_LO), int'(RCP_EXP_HI) - 1));
        else ex = 11'($urandom_range(1, int'(EXP_MAX) - 1));
        return {sgn, ex, r[51:0]};
      end
    endcase
  endfunction

  // result side: random ready/stall bursts, one long hold-off, always ready at the end
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (quiet_tail) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // signed zeros, infinities and nans for both operations
    send_request(CMD_RSQRT, 64'h0000_0000_0000_0000);
    send_request(CMD_RECIP, 64'h0000_0000_0000_0000);
    send_request(CMD_RSQRT, 64'h8000_0000_0000_0000);
    send_request(CMD_RECIP, 64'h8000_0000_0000_0000);
    send_request(CMD_RSQRT, 64'h7FF0_0000_0000_0000);
    send_request(CMD_RECIP, 64'h7FF0_0000_0000_0000);
    send_request(CMD_RSQRT, 64'hFFF0_0000_0000_0000);
    send_request(CMD_RECIP, 64'hFFF0_0000_0000_0000);
    send_request(CMD_RSQRT, 64'h7FF0_0000_0000_0001);
    send_request(CMD_RECIP, 64'h7FF0_0000_0000_0001);
    send_request(CMD_RSQRT, 64'hFFF8_0000_0000_1234);
    send_request(CMD_RECIP, 64'hFFF8_0000_0000_1234);
    // ordinary values, negative rsqrt operand, subnormal extremes
    send_request(CMD_RSQRT, 64'h3FF0_0000_0000_0000);
    send_request(CMD_RECIP, 64'h3FF0_0000_0000_0000);
    send_request(CMD_RSQRT, 64'hBFF0_0000_0000_0000);
    send_request(CMD_RSQRT, 64'h0000_0000_0000_0001);
    send_request(CMD_RECIP, 64'h0000_0000_0000_0001);
    send_request(CMD_RSQRT, 64'h000F_FFFF_FFFF_FFFF);
    send_request(CMD_RECIP, 64'h800F_FFFF_FFFF_FFFF);
    // reciprocal saturate and flush thresholds
    send_request(CMD_RECIP, 64'h37EF_FFFF_FFFF_FFFF);
    send_request(CMD_RECIP, 64'h37F0_0000_0000_0000);
    send_request(CMD_RECIP, 64'hC7CF_FFFF_FFFF_FFFF);
    send_request(CMD_RECIP, 64'h47D0_0000_0000_0000);
    send_request(CMD_RSQRT, 64'h7FEF_FFFF_FFFF_FFFF);
    wait_drained();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 500) begin
        // back-to-back requests against a long result stall
        gaps_on  = 1'b0;
        hold_req = 1'b1;
      end
      if (i == 600) gaps_on = 1'b1;
      if (i == 1000) wait_drained();
      if (i == NUM_RANDOM - 300) begin
        gaps_on    = 1'b0;
        quiet_tail = 1'b1;
      end
      send_request(cmd_e'($urandom_range(0, 1)), random_operand());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/fpre_pkg.sv
rtl/fpre_decode.sv
rtl/fpre_lookup.sv
rtl/fpre_mul.sv
rtl/fpre_pack.sv
rtl/fp_reciprocal_estimate_unit_top.sv
rtl/fpre_checker.sv
tb/sv/fpre_estimate_checker.sv
tb/sv/tb_fp_reciprocal_estimate_unit_top.sv
